/* sv/binary_image_projection_profile_assert.svh */
// Assertion macros for the binary image projection profile.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BINARY_IMAGE_PROJECTION_PROFILE_ASSERT_SVH
`define BINARY_IMAGE_PROJECTION_PROFILE_ASSERT_SVH

// same-cycle implication
`define BIPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BIPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bipp_pkg.sv */
// Shared types, constants and helpers for the binary image projection profile.
// No dependencies.
package bipp_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned RegW  = 11;
  localparam int unsigned CntW  = 11;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned PixW  = 8;
  localparam int unsigned Lanes = 8;
  localparam int unsigned LaneW = 3;
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [RegW-1:0] RegResetVal = 11'd1024;

  typedef enum logic [KindW-1:0] {
    KIND_ROW   = 2'd0,
    KIND_COL   = 2'd1,
    KIND_RANGE = 2'd2
  } kind_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [Lanes-1:0][CntW-1:0] cword_t;

  typedef struct packed {
    kind_e           kind;
    logic [IdxW-1:0] index;
    logic [CntW-1:0] count;
    logic            last_row;
  } result_t;

  typedef struct packed {
    logic             is_read;
    logic             first_row;
    logic [Lanes-1:0] black;
    logic [Lanes-1:0] wmask;
    logic [LaneW-1:0] lane;
    logic             has_res;
    result_t          res;
  } rmw_req_t;

  function automatic logic [3:0] popcount8(input logic [Lanes-1:0] v);
    logic [3:0] s;
    s = 4'd0;
    for (int k = 0; k < Lanes; k++) begin
      s = s + {3'd0, v[k]};
    end
    return s;
  endfunction

endpackage

/* sv/bipp_col_store.sv */
// Column count memory with read-modify-write and write-to-read forwarding.
// Depends on bipp_pkg.
module bipp_col_store #(
  parameter int unsigned NWords = 128,
  parameter int unsigned AddrW  = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [AddrW-1:0]    rd_addr_i,
  input  logic                req_valid_i,
  input  bipp_pkg::rmw_req_t  req_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  output bipp_pkg::result_t   res_o
);
  import bipp_pkg::*;

  cword_t mem_q [NWords];
  cword_t rd_q;
  cword_t fwd_data_q;
  logic   fwd_q;
  cword_t cur_word;
  cword_t new_word;
  logic   wr_en;

  assign wr_en    = req_valid_i && !req_i.is_read;
  assign cur_word = fwd_q ? fwd_data_q : rd_q;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      if (req_i.wmask[k]) begin
        if (req_i.first_row) begin
          new_word[k] = {{(CntW-1){1'b0}}, req_i.black[k]};
        end else begin
          new_word[k] = cur_word[k] + {{(CntW-1){1'b0}}, req_i.black[k]};
        end
      end else begin
        new_word[k] = cur_word[k];
      end
    end
  end

  always_comb begin
    res_o = req_i.res;
    if (req_i.is_read && req_i.res.kind == KIND_COL) begin
      res_o.count = cur_word[req_i.lane];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
    if (wr_en) begin
      mem_q[wr_addr_i] <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_en && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= new_word;
  end

endmodule

/* sv/binary_image_projection_profile.sv */
// Binary image projection profile: takes one word per cycle unless in_stall_o is high,
// either a packed byte of eight 1-bit pixels (row-major, bit k is column 8*byte+k, 0 is
// black) or a column count read. Each row's black count comes out after the row's last
// byte, flagged on the image's final row; a read returns the stored count of one column,
// or an out-of-range word past the image width. Throughput is one word per clock while
// in_stall_o is low. On the way to the output, the column memory is read at the edge that
// takes a word, and the next cycle updates the counts, writes them back and loads the
// output queue. Column counts live in a memory of ceil(MAX_WIDTH/8) entries of eight
// counts; row 0 of each image overwrites them, so a column is readable only after a first
// row has passed it. A two-entry output queue lets input continue while a result waits.
// Depends on bipp_pkg and bipp_col_store.
`include "binary_image_projection_profile_assert.svh"

module binary_image_projection_profile #(
  parameter int unsigned MAX_WIDTH  = bipp_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = bipp_pkg::MaxHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bipp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bipp_pkg::RegW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [bipp_pkg::PixW-1:0]   pixel_byte_i,
  input  logic [bipp_pkg::IdxW-1:0]   column_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bipp_pkg::KindW-1:0]  kind_o,
  output logic [bipp_pkg::IdxW-1:0]   index_o,
  output logic [bipp_pkg::CntW-1:0]   count_o,
  output logic                        last_row_o
);
  import bipp_pkg::*;

  localparam int unsigned NWords = (MAX_WIDTH + 7) / 8;
  localparam int unsigned AW     = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned XW0    = (AW + LaneW > RW) ? AW + LaneW : RW;
  localparam int unsigned XW     = ((XW0 > RegW) ? XW0 : RegW) + 2;

  logic [RegW-1:0] cfg_width_q, cfg_height_q;
  logic [RegW-1:0] width, height;
  logic [XW-1:0]   bytes_per_row;

  logic [CntW-1:0] row_acc_q, row_acc_d;
  logic [AW-1:0]   byte_pos_q, byte_pos_d;
  logic [RW-1:0]   row_pos_q, row_pos_d;

  logic            accept;
  logic [Lanes-1:0] wmask;
  logic [Lanes-1:0] black;
  logic [CntW-1:0] row_sum;
  logic            end_row, last;
  logic [AW-1:0]   rd_addr;
  rmw_req_t        req_d;

  logic            s1_valid_q;
  rmw_req_t        s1_q;
  logic [AW-1:0]   s1_addr_q;
  result_t         s1_res;

  result_t         q_q [2];
  logic [1:0]      q_cnt_q;
  logic            push, pop;
  logic [2:0]      cnt_after;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RegResetVal;
      cfg_height_q <= RegResetVal;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        REG_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    width = cfg_width_q;
    if (width == '0) width = RegW'(1);
    if (XW'(width) > XW'(MAX_WIDTH)) width = RegW'(MAX_WIDTH);
    height = cfg_height_q;
    if (height == '0) height = RegW'(1);
    if (XW'(height) > XW'(MAX_HEIGHT)) height = RegW'(MAX_HEIGHT);
    bytes_per_row = (XW'(width) + XW'(7)) >> 3;
  end

  // front stage: decode the word, update row state, issue the memory read
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      wmask[k] = XW'({byte_pos_q, LaneW'(k)}) < XW'(width);
    end
    black   = ~pixel_byte_i & wmask;
    row_sum = row_acc_q + CntW'(popcount8(black));
    end_row = (XW'(byte_pos_q) + XW'(1)) >= bytes_per_row;
    last    = (XW'(row_pos_q) + XW'(1)) >= XW'(height);
  end

  always_comb begin
    req_d              = '0;
    req_d.first_row    = (row_pos_q == '0);
    req_d.lane         = column_index_i[LaneW-1:0];
    rd_addr            = byte_pos_q;
    row_acc_d          = row_acc_q;
    byte_pos_d         = byte_pos_q;
    row_pos_d          = row_pos_q;
    if (action_i == ACT_READ) begin
      req_d.is_read    = 1'b1;
      req_d.has_res    = 1'b1;
      req_d.res.index  = column_index_i;
      rd_addr          = AW'(column_index_i >> LaneW);
      if (RegW'(column_index_i) >= width) begin
        req_d.res.kind = KIND_RANGE;
      end else begin
        req_d.res.kind = KIND_COL;
      end
    end else begin
      req_d.black      = black;
      req_d.wmask      = wmask;
      req_d.res.kind   = KIND_ROW;
      req_d.res.index  = IdxW'(row_pos_q);
      req_d.res.count  = row_sum;
      req_d.res.last_row = last;
      if (end_row) begin
        req_d.has_res  = 1'b1;
        row_acc_d      = '0;
        byte_pos_d     = '0;
        row_pos_d      = last ? '0 : row_pos_q + RW'(1);
      end else begin
        row_acc_d      = row_sum;
        byte_pos_d     = byte_pos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_acc_q  <= '0;
      byte_pos_q <= '0;
      row_pos_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept && action_i == ACT_PIXEL) begin
        row_acc_q  <= row_acc_d;
        byte_pos_q <= byte_pos_d;
        row_pos_q  <= row_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= req_d;
    s1_addr_q <= rd_addr;
  end

  // memory stage
  bipp_col_store #(
    .NWords (NWords),
    .AddrW  (AW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (rd_addr),
    .req_valid_i (s1_valid_q),
    .req_i       (s1_q),
    .wr_addr_i   (s1_addr_q),
    .res_o       (s1_res)
  );

  // output queue
  assign push      = s1_valid_q && s1_q.has_res;
  assign pop       = (q_cnt_q != 2'd0) && !out_stall_i;
  assign cnt_after = 3'(q_cnt_q) + 3'(push) - 3'(pop);
  assign in_stall_o = cnt_after >= 3'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= 2'd0;
    end else begin
      q_cnt_q <= cnt_after[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (q_cnt_q == 2'd2) begin
        q_q[0] <= q_q[1];
        if (push) q_q[1] <= s1_res;
      end else if (push) begin
        q_q[0] <= s1_res;
      end
    end else if (push) begin
      if (q_cnt_q == 2'd0) begin
        q_q[0] <= s1_res;
      end else begin
        q_q[1] <= s1_res;
      end
    end
  end

  assign out_valid_o = (q_cnt_q != 2'd0);
  assign kind_o      = q_q[0].kind;
  assign index_o     = q_q[0].index;
  assign count_o     = q_q[0].count;
  assign last_row_o  = q_q[0].last_row;

  `BIPP_ASSERT_NOW(a_queue_bound, 1'b1, q_cnt_q <= 2'd2, "output queue overflow")
  `BIPP_ASSERT_NOW(a_range_zero, out_valid_o && kind_o == KIND_RANGE,
                   count_o == '0 && !last_row_o, "range word carries data")
  `BIPP_ASSERT_NOW(a_col_not_last, out_valid_o && kind_o == KIND_COL,
                   !last_row_o, "column word flagged last row")
  `BIPP_ASSERT_NEXT(a_row_wrap, accept && action_i == ACT_PIXEL && end_row && last,
                    row_pos_q == '0 && byte_pos_q == '0, "final row did not wrap")

endmodule
